/* hw/rtl/bsr_pkg.sv */
// Shared types and constants for the bisection square root block.
// No dependencies; imported by bsr_cell and bisection_square_root_top.
`timescale 1ns / 1ps

package bsr_pkg;

   localparam int DATA_W      = 32;  // Q16.16 operand width
   localparam int PASS_W      = 7;   // pass counter and limit width
   localparam int SQ_W        = 2 * DATA_W;  // exact square width
   localparam int CSR_INDEX_W = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ITER_LIMIT = CSR_INDEX_W'(1);

   localparam logic [DATA_W-1:0] TOLERANCE_RESET = DATA_W'(6554);
   localparam logic [PASS_W-1:0] ITER_LIMIT_RESET = PASS_W'(48);

   // Search state handed from cell to cell.
   typedef struct packed {
      logic [DATA_W-1:0] radicand;
      logic [DATA_W-1:0] low;
      logic [DATA_W-1:0] high;
      logic [SQ_W-1:0]   low_sq;
      logic [SQ_W-1:0]   high_sq;
      logic [DATA_W-1:0] root;    // last midpoint until the search stops
      logic [PASS_W-1:0] passes;
      logic              done;
      logic              conv;
   } srch_type;

endpackage

/* hw/rtl/bsr_cell.sv */
// One bisection pass: bound checks and midpoint square, then tolerance check and update.
// Depends on bsr_pkg.
`timescale 1ns / 1ps

module bsr_cell import bsr_pkg::*; #(
   parameter int FRACTION_BITS = 16,
   parameter int PASS_INDEX    = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              in_valid,
   input  srch_type          in_state,
   input  logic [PASS_W-1:0] limit,
   input  logic [DATA_W-1:0] tolerance,
   output logic              out_valid,
   output srch_type          out_state
);

   localparam logic [PASS_W-1:0] THIS_PASS = PASS_W'(PASS_INDEX);
   localparam logic [PASS_W-1:0] NEXT_PASS = PASS_W'(PASS_INDEX + 1);

   // First half: exact-bound checks, midpoint and its square
   logic [DATA_W:0]   sum_a;
   logic [DATA_W-1:0] mid_a;
   logic [SQ_W-1:0]   target_a;
   srch_type          a_state_in;
   logic              a_search_in;
   logic [SQ_W-1:0]   a_sq_in;

   logic              a_valid_ff;
   srch_type          a_state_ff;
   logic              a_search_ff;
   logic [DATA_W-1:0] a_mid_ff;
   logic [SQ_W-1:0]   a_sq_ff;

   assign sum_a    = {1'b0, in_state.low} + {1'b0, in_state.high};
   assign mid_a    = sum_a[DATA_W:1];
   assign target_a = SQ_W'(in_state.radicand) << FRACTION_BITS;
   assign a_sq_in  = SQ_W'(mid_a) * SQ_W'(mid_a);

   always_comb begin
      a_state_in  = in_state;
      a_search_in = 1'b0;
      priority if (in_state.done) begin
         a_search_in = 1'b0;
      end else if (THIS_PASS >= limit) begin
         a_state_in.done = 1'b1;
         a_state_in.conv = 1'b0;
      end else if (in_state.low_sq == target_a) begin
         a_state_in.done = 1'b1;
         a_state_in.conv = 1'b1;
         a_state_in.root = in_state.low;
      end else if (in_state.high_sq == target_a) begin
         a_state_in.done = 1'b1;
         a_state_in.conv = 1'b1;
         a_state_in.root = in_state.high;
      end else begin
         a_search_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_state_ff  <= a_state_in;
         a_search_ff <= a_search_in;
         a_mid_ff    <= mid_a;
         a_sq_ff     <= a_sq_in;
      end
   end

   // Second half: tolerance check, then move one bound to the midpoint
   logic [SQ_W-1:0] target_b;
   logic [SQ_W-1:0] tol_b;
   logic [SQ_W-1:0] diff_b;
   logic            below_b;
   srch_type        b_state_in;

   logic            b_valid_ff;
   srch_type        b_state_ff;

   assign target_b = SQ_W'(a_state_ff.radicand) << FRACTION_BITS;
   assign tol_b    = SQ_W'(tolerance) << FRACTION_BITS;
   assign below_b  = a_sq_ff < target_b;
   assign diff_b   = below_b ? (target_b - a_sq_ff) : (a_sq_ff - target_b);

   always_comb begin
      b_state_in = a_state_ff;
      if (a_search_ff) begin
         b_state_in.root = a_mid_ff;
         if (diff_b <= tol_b) begin
            b_state_in.done = 1'b1;
            b_state_in.conv = 1'b1;
         end else begin
            if (below_b) begin
               b_state_in.low    = a_mid_ff;
               b_state_in.low_sq = a_sq_ff;
            end else begin
               b_state_in.high    = a_mid_ff;
               b_state_in.high_sq = a_sq_ff;
            end
            b_state_in.passes = NEXT_PASS;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_state_ff <= b_state_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_state = b_state_ff;

endmodule

/* hw/rtl/bisection_square_root_top.sv */
// Throughput: one request per cycle while no result is held; each of the
//   MAX_PASSES cells does one bisection pass in two register stages
//   (midpoint square, then compare and update).
// The input register takes a request while a finished result waits to be taken, but only if it is empty.
// Reset clears all valid bits and loads tolerance 6554 (0.1) and iteration limit 48.
// Top level of the bisection square root; depends on bsr_pkg and bsr_cell.
`timescale 1ns / 1ps

module bisection_square_root_top import bsr_pkg::*; #(
   parameter int FRACTION_BITS = 16,
   parameter int MAX_PASSES    = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [DATA_W-1:0]      req_radicand,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [DATA_W-1:0]      rsp_root,
   output logic [PASS_W-1:0]      rsp_passes,
   output logic                   rsp_converged,
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]      csr_data
);

   localparam logic [PASS_W-1:0] MAX_LIMIT = PASS_W'(MAX_PASSES);
   localparam logic [DATA_W-1:0] ONE       = DATA_W'(1) << FRACTION_BITS;

   // ---------------------------------------------------------------
   // Configuration registers; always ready, writes beyond the list drop
   // ---------------------------------------------------------------
   logic [DATA_W-1:0] tolerance_ff;
   logic [PASS_W-1:0] iter_limit_ff;
   logic [PASS_W-1:0] eff_limit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff  <= TOLERANCE_RESET;
         iter_limit_ff <= ITER_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TOLERANCE:  tolerance_ff  <= csr_data;
            CSR_ITER_LIMIT: iter_limit_ff <= csr_data[PASS_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the limit to 1..MAX_PASSES
   always_comb begin
      priority if (iter_limit_ff == '0) begin
         eff_limit = PASS_W'(1);
      end else if (iter_limit_ff > MAX_LIMIT) begin
         eff_limit = MAX_LIMIT;
      end else begin
         eff_limit = iter_limit_ff;
      end
   end

   // ---------------------------------------------------------------
   // Global advance: the whole chain moves unless the result is held
   // ---------------------------------------------------------------
   logic advance;
   logic accept;
   logic rsp_valid_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;

   // Input register: hold the request; refill whenever it empties or moves on
   logic              in_valid_ff;
   logic [DATA_W-1:0] in_radicand_ff;

   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_radicand_ff <= req_radicand;
      end
   end

   // ---------------------------------------------------------------
   // Start stage: interval [0, max(1.0, radicand)] and the high square
   // ---------------------------------------------------------------
   logic [DATA_W-1:0] high_in;
   srch_type          init_state_in;
   logic              init_valid_ff;
   srch_type          init_state_ff;

   assign high_in = (in_radicand_ff < ONE) ? ONE : in_radicand_ff;

   always_comb begin
      init_state_in          = '0;
      init_state_in.radicand = in_radicand_ff;
      init_state_in.high     = high_in;
      init_state_in.high_sq  = SQ_W'(high_in) * SQ_W'(high_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_valid_ff <= 1'b0;
      end else if (advance) begin
         init_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         init_state_ff <= init_state_in;
      end
   end

   // ---------------------------------------------------------------
   // Row of pass cells; cell k does pass k and hands on to cell k+1
   // ---------------------------------------------------------------
   logic     chain_valid [0:MAX_PASSES];
   srch_type chain_state [0:MAX_PASSES];

   assign chain_valid[0] = init_valid_ff;
   assign chain_state[0] = init_state_ff;

   for (genvar k = 0; k < MAX_PASSES; k++) begin : g_cell
      bsr_cell #(
         .FRACTION_BITS (FRACTION_BITS),
         .PASS_INDEX    (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (chain_valid[k]),
         .in_state  (chain_state[k]),
         .limit     (eff_limit),
         .tolerance (tolerance_ff),
         .out_valid (chain_valid[k+1]),
         .out_state (chain_state[k+1])
      );
   end

   // ---------------------------------------------------------------
   // Result register. A search still open after the last cell has hit
   // the full limit: root is the last midpoint, converged stays clear.
   // ---------------------------------------------------------------
   srch_type          last_state;
   logic [DATA_W-1:0] rsp_root_ff;
   logic [PASS_W-1:0] rsp_passes_ff;
   logic              rsp_conv_ff;

   assign last_state = chain_state[MAX_PASSES];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= chain_valid[MAX_PASSES];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_root_ff   <= last_state.root;
         rsp_passes_ff <= last_state.passes;
         rsp_conv_ff   <= last_state.done && last_state.conv;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_root      = rsp_root_ff;
   assign rsp_passes    = rsp_passes_ff;
   assign rsp_converged = rsp_conv_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // Reset empties both ends of the chain.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("valid bits not cleared by reset");

   // A search given up at the limit has run at least one pass.
   a_limit_passes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_conv_ff |-> rsp_passes_ff != '0)
      else $error("limit stop with zero passes");

   // Pass count never exceeds the number of cells.
   a_pass_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_passes_ff <= MAX_LIMIT)
      else $error("pass count beyond cell count");

   // A held result freezes the last cell.
   a_chain_frozen: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain_valid[MAX_PASSES]) && $stable(last_state))
      else $error("chain moved while result held");

endmodule
